// ===== rtl/core/rsi_pkg.sv =====
// Shared constants and types for the ray/sphere intersection core.
// No dependencies; used by the top level of the core.
`default_nettype none

package rsi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X  = 3'd0,
        CFG_CENTER_Y  = 3'd1,
        CFG_CENTER_Z  = 3'd2,
        CFG_RADIUS    = 3'd3,
        CFG_MAX_RANGE = 3'd4
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsi_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
// Self-contained; carries an opaque side vector alongside each operand.
`default_nettype none

module rsi_sqrt_pipe #(
    parameter int ROOT_W = 68,
    parameter int SIDE_W = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic                       out_valid,
    output logic [ROOT_W-1:0]          root,
    output logic [SIDE_W-1:0]          side_out
);

    localparam int REM_W = ROOT_W + 3;

    logic [REM_W-1:0]    rem_reg  [1:ROOT_W];
    logic [ROOT_W-1:0]   root_reg [1:ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg  [1:ROOT_W];
    logic [SIDE_W-1:0]   side_reg [1:ROOT_W];
    logic                vld_reg  [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0]    rem_in;
        logic [REM_W-1:0]    rem_sh;
        logic [REM_W-1:0]    trial;
        logic [REM_W-1:0]    rem_next;
        logic [ROOT_W-1:0]   root_in;
        logic [2*ROOT_W-1:0] rad_in;
        logic [SIDE_W-1:0]   side_k;
        logic                vld_in;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign side_k  = side_in;
            assign vld_in  = in_valid;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign rad_in  = rad_reg[k];
            assign side_k  = side_reg[k];
            assign vld_in  = vld_reg[k];
        end

        // bring down the next pair of radicand bits and try root*4+1
        assign rem_sh   = {rem_in[REM_W-3:0], rad_in[2*ROOT_W-1 -: 2]};
        assign trial    = {1'b0, root_in, 2'b01};
        assign ge       = (rem_sh >= trial);
        assign rem_next = ge ? (rem_sh - trial) : rem_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= {root_in[ROOT_W-2:0], ge};
                rad_reg[k+1]  <= rad_in << 2;
                side_reg[k+1] <= side_k;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];
    assign side_out  = side_reg[ROOT_W];

endmodule

`default_nettype wire

// ===== rtl/core/rsi_div_pipe.sv =====
// Pipelined restoring divider: quotient of (num << FRAC_W) / den, one bit per stage.
// Self-contained; flags quotients that do not fit in Q_W bits.
`default_nettype none

module rsi_div_pipe #(
    parameter int NUM_W  = 69,
    parameter int DEN_W  = 64,
    parameter int Q_W    = 31,
    parameter int FRAC_W = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quo,
    output logic                   ovf,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int A_W   = NUM_W + FRAC_W;
    localparam int B_W   = DEN_W + Q_W;
    localparam int REM_W = ((A_W > B_W) ? A_W : B_W) + 1;

    logic [REM_W-1:0]  rem_reg  [0:Q_W];
    logic [DEN_W-1:0]  den_reg  [0:Q_W];
    logic [Q_W-1:0]    q_reg    [0:Q_W];
    logic              ovf_reg  [0:Q_W];
    logic [SIDE_W-1:0] side_reg [0:Q_W];
    logic              vld_reg  [0:Q_W];

    logic [REM_W-1:0] num_sh;
    logic [REM_W-1:0] den_top;

    assign num_sh  = REM_W'(num) << FRAC_W;
    assign den_top = REM_W'(den) << Q_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    // quotient overflows unless the dividend stays below den << Q_W
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num_sh;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= (num_sh >= den_top);
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [REM_W-1:0] sub;
        logic             ge;

        assign sub = REM_W'(den_reg[k]) << (Q_W - 1 - k);
        assign ge  = (rem_reg[k] >= sub);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? (rem_reg[k] - sub) : rem_reg[k];
                den_reg[k+1]  <= den_reg[k];
                q_reg[k+1]    <= {q_reg[k][Q_W-2:0], ge};
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign quo       = q_reg[Q_W];
    assign ovf       = ovf_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

`default_nettype wire

// ===== rtl/core/ray_sphere_intersection_core.sv =====
// Pipeline: five front stages, one per root bit in the square root, one for the crossing
// numerators, one per quotient bit plus one in the dividers, three for the point.
// Throughput: one ray per cycle; the whole pipeline holds while the output is stalled.
// Reset: asynchronous, active low; clears valid bits, centre 0, radius 1.0, range all ones.
// Depends on rsi_pkg, rsi_sqrt_pipe and rsi_div_pipe.
`default_nettype none

module ray_sphere_intersection_core #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]        cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] origin_x,
    input  wire logic signed [COORD_WIDTH-1:0] origin_y,
    input  wire logic signed [COORD_WIDTH-1:0] origin_z,
    input  wire logic signed [COORD_WIDTH-1:0] dir_x,
    input  wire logic signed [COORD_WIDTH-1:0] dir_y,
    input  wire logic signed [COORD_WIDTH-1:0] dir_z,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               hit,
    output logic signed [COORD_WIDTH-1:0]      point_x,
    output logic signed [COORD_WIDTH-1:0]      point_y,
    output logic signed [COORD_WIDTH-1:0]      point_z
);

    localparam int W     = COORD_WIDTH;
    localparam int VW    = W + 1;
    localparam int DDW   = 2 * W;
    localparam int ODW   = 2 * W + 2;
    localparam int OOW   = 2 * W + 3;
    localparam int DELW  = 4 * W + 4;
    localparam int RW    = 2 * W + 4;
    localparam int NUMW  = RW + 2;
    localparam int QW    = W - 1;
    localparam int SUMW  = 2 * W + 1;
    localparam int SQ_SIDE  = 1 + ODW + DDW + 6 * W;
    localparam int DIV_SIDE = 2 + 6 * W;

    // ---------------- configuration ----------------
    logic signed [W-1:0] cen_reg [0:2];
    logic [W-2:0]        rad_reg;
    logic [W-2:0]        mr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg[0] <= '0;
            cen_reg[1] <= '0;
            cen_reg[2] <= '0;
            rad_reg    <= (W-1)'(1) << FRAC_BITS;
            mr_reg     <= '1;
        end
        else if (cfg_wen)
        begin
            unique case (rsi_pkg::cfg_idx_t'(cfg_index))
                rsi_pkg::CFG_CENTER_X:  cen_reg[0] <= cfg_data;
                rsi_pkg::CFG_CENTER_Y:  cen_reg[1] <= cfg_data;
                rsi_pkg::CFG_CENTER_Z:  cen_reg[2] <= cfg_data;
                rsi_pkg::CFG_RADIUS:    rad_reg    <= cfg_data[W-2:0];
                rsi_pkg::CFG_MAX_RANGE: mr_reg     <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    logic signed [W-1:0] org_in [0:2];
    logic signed [W-1:0] dir_in [0:2];

    assign org_in[0] = origin_x;
    assign org_in[1] = origin_y;
    assign org_in[2] = origin_z;
    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;

    // ---------------- stage 1: offset from centre ----------------
    logic                 v1_reg;
    logic signed [VW-1:0] off1_reg [0:2];
    logic signed [W-1:0]  org1_reg [0:2];
    logic signed [W-1:0]  dir1_reg [0:2];

    // ---------------- stage 2: products ----------------
    logic                    v2_reg;
    logic signed [2*W-1:0]   ddp2_reg [0:2];
    logic signed [2*W:0]     odp2_reg [0:2];
    logic signed [2*W+1:0]   oop2_reg [0:2];
    logic [2*W-3:0]          rr2_reg;
    logic signed [W-1:0]     org2_reg [0:2];
    logic signed [W-1:0]     dir2_reg [0:2];

    // ---------------- stage 3: sums ----------------
    logic                    v3_reg;
    logic [DDW-1:0]          dd3_reg;
    logic signed [ODW-1:0]   od3_reg;
    logic signed [OOW-1:0]   oo3_reg;
    logic signed [W-1:0]     org3_reg [0:2];
    logic signed [W-1:0]     dir3_reg [0:2];

    // ---------------- stage 4: partial products ----------------
    logic                    v4_reg;
    logic [2*W-1:0]          hh4_reg;
    logic [2*W:0]            hl4_reg;
    logic [2*W+1:0]          ll4_reg;
    logic [2*W:0]            dlol4_reg;
    logic [2*W:0]            dloh4_reg;
    logic [2*W:0]            dhol4_reg;
    logic [2*W:0]            dhoh4_reg;
    logic                    ooneg4_reg;
    logic                    ddz4_reg;
    logic [DDW-1:0]          dd4_reg;
    logic signed [ODW-1:0]   od4_reg;
    logic signed [W-1:0]     org4_reg [0:2];
    logic signed [W-1:0]     dir4_reg [0:2];

    // ---------------- stage 5: discriminant ----------------
    logic                    v5_reg;
    logic [DELW-1:0]         del5_reg;
    logic                    miss5_reg;
    logic [DDW-1:0]          dd5_reg;
    logic signed [ODW-1:0]   od5_reg;
    logic signed [W-1:0]     org5_reg [0:2];
    logic signed [W-1:0]     dir5_reg [0:2];

    logic signed [ODW-1:0]   od_mag3;
    logic [OOW-1:0]          oo_mag3;
    logic signed [2*W+2:0]   dd_sum;
    logic [DELW-1:0]         od2_w;
    logic [DELW-1:0]         ddoo_w;
    logic [DELW-1:0]         del_w;

    assign dd_sum = (2*W+3)'(ddp2_reg[0]) + (2*W+3)'(ddp2_reg[1]) + (2*W+3)'(ddp2_reg[2]);
    assign od_mag3 = od3_reg[ODW-1] ? -od3_reg : od3_reg;
    assign oo_mag3 = oo3_reg[OOW-1] ? OOW'(-oo3_reg) : OOW'(oo3_reg);

    assign od2_w  = (DELW'(hh4_reg) << (2 * (W + 1))) + (DELW'(hl4_reg) << (W + 2))
                  + DELW'(ll4_reg);
    assign ddoo_w = (DELW'(dhoh4_reg) << (2 * W + 1)) + (DELW'(dhol4_reg) << W)
                  + (DELW'(dloh4_reg) << (W + 1)) + DELW'(dlol4_reg);
    assign del_w  = ooneg4_reg ? (od2_w + ddoo_w) : (od2_w - ddoo_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                off1_reg[i] <= VW'(org_in[i]) - VW'(cen_reg[i]);
                org1_reg[i] <= org_in[i];
                dir1_reg[i] <= dir_in[i];

                ddp2_reg[i] <= dir1_reg[i] * dir1_reg[i];
                odp2_reg[i] <= (2*W+1)'(off1_reg[i]) * (2*W+1)'(dir1_reg[i]);
                oop2_reg[i] <= (2*W+2)'(off1_reg[i]) * (2*W+2)'(off1_reg[i]);
                org2_reg[i] <= org1_reg[i];
                dir2_reg[i] <= dir1_reg[i];

                org3_reg[i] <= org2_reg[i];
                dir3_reg[i] <= dir2_reg[i];
                org4_reg[i] <= org3_reg[i];
                dir4_reg[i] <= dir3_reg[i];
                org5_reg[i] <= org4_reg[i];
                dir5_reg[i] <= dir4_reg[i];
            end
            rr2_reg <= (2*W-2)'(rad_reg) * (2*W-2)'(rad_reg);

            dd3_reg <= dd_sum[DDW-1:0];
            od3_reg <= ODW'(odp2_reg[0]) + ODW'(odp2_reg[1]) + ODW'(odp2_reg[2]);
            oo3_reg <= OOW'(oop2_reg[0]) + OOW'(oop2_reg[1]) + OOW'(oop2_reg[2])
                     - $signed(OOW'(rr2_reg));

            // split the wide squares into products of about one word each
            hh4_reg    <= od_mag3[2*W:W+1] * od_mag3[2*W:W+1];
            hl4_reg    <= (2*W+1)'(od_mag3[2*W:W+1]) * (2*W+1)'(od_mag3[W:0]);
            ll4_reg    <= (2*W+2)'(od_mag3[W:0]) * (2*W+2)'(od_mag3[W:0]);
            dlol4_reg  <= (2*W+1)'(dd3_reg[W-1:0]) * (2*W+1)'(oo_mag3[W:0]);
            dloh4_reg  <= (2*W+1)'(dd3_reg[W-1:0]) * (2*W+1)'(oo_mag3[2*W+1:W+1]);
            dhol4_reg  <= (2*W+1)'(dd3_reg[2*W-1:W]) * (2*W+1)'(oo_mag3[W:0]);
            dhoh4_reg  <= (2*W+1)'(dd3_reg[2*W-1:W]) * (2*W+1)'(oo_mag3[2*W+1:W+1]);
            ooneg4_reg <= oo3_reg[OOW-1];
            ddz4_reg   <= (dd3_reg == '0);
            dd4_reg    <= dd3_reg;
            od4_reg    <= od3_reg;

            del5_reg  <= del_w;
            miss5_reg <= ddz4_reg || del_w[DELW-1];
            dd5_reg   <= dd4_reg;
            od5_reg   <= od4_reg;
        end
    end

    // ---------------- square root ----------------
    logic [2*RW-1:0]    rad_in;
    logic [SQ_SIDE-1:0] sq_side_in;
    logic [SQ_SIDE-1:0] sq_side_out;
    logic               sq_valid;
    logic [RW-1:0]      sq_root;

    assign rad_in     = miss5_reg ? '0 : (2*RW)'(del5_reg);
    assign sq_side_in = {miss5_reg, od5_reg, dd5_reg,
                         org5_reg[0], org5_reg[1], org5_reg[2],
                         dir5_reg[0], dir5_reg[1], dir5_reg[2]};

    rsi_sqrt_pipe #(
        .ROOT_W (RW),
        .SIDE_W (SQ_SIDE)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v5_reg),
        .radicand  (rad_in),
        .side_in   (sq_side_in),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side_out)
    );

    logic                  sq_miss;
    logic signed [ODW-1:0] sq_od;
    logic [DDW-1:0]        sq_dd;
    logic [6*W-1:0]        sq_vec;

    assign {sq_miss, sq_od, sq_dd, sq_vec} = sq_side_out;

    // ---------------- stage 6: crossing numerators ----------------
    logic                   v6_reg;
    logic [NUMW-2:0]        nlo6_reg;
    logic [NUMW-2:0]        nhi6_reg;
    logic                   lneg6_reg;
    logic                   hneg6_reg;
    logic                   miss6_reg;
    logic [DDW-1:0]         dd6_reg;
    logic [6*W-1:0]         vec6_reg;

    logic signed [NUMW-1:0] negod_w;
    logic signed [NUMW-1:0] root_w;
    logic signed [NUMW-1:0] nlo_w;
    logic signed [NUMW-1:0] nhi_w;

    assign negod_w = -NUMW'(sq_od);
    assign root_w  = $signed(NUMW'(sq_root));
    assign nlo_w   = negod_w - root_w;
    assign nhi_w   = negod_w + root_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nlo6_reg  <= nlo_w[NUMW-1] ? '0 : nlo_w[NUMW-2:0];
            nhi6_reg  <= nhi_w[NUMW-1] ? '0 : nhi_w[NUMW-2:0];
            lneg6_reg <= nlo_w[NUMW-1];
            hneg6_reg <= nhi_w[NUMW-1];
            miss6_reg <= sq_miss;
            dd6_reg   <= sq_dd;
            vec6_reg  <= sq_vec;
        end
    end

    // ---------------- dividers ----------------
    logic                dv_valid;
    logic                dv_unused_valid;
    logic [QW-1:0]       qlo;
    logic [QW-1:0]       qhi;
    logic                lo_ovf;
    logic                hi_ovf;
    logic [DIV_SIDE-1:0] dv_side;
    logic                hi_neg_d;

    rsi_div_pipe #(
        .NUM_W  (NUMW - 1),
        .DEN_W  (DDW),
        .Q_W    (QW),
        .FRAC_W (FRAC_BITS),
        .SIDE_W (DIV_SIDE)
    ) u_div_near (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v6_reg),
        .num       (nlo6_reg),
        .den       (dd6_reg),
        .side_in   ({miss6_reg, lneg6_reg, vec6_reg}),
        .out_valid (dv_valid),
        .quo       (qlo),
        .ovf       (lo_ovf),
        .side_out  (dv_side)
    );

    rsi_div_pipe #(
        .NUM_W  (NUMW - 1),
        .DEN_W  (DDW),
        .Q_W    (QW),
        .FRAC_W (FRAC_BITS),
        .SIDE_W (1)
    ) u_div_far (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v6_reg),
        .num       (nhi6_reg),
        .den       (dd6_reg),
        .side_in   (hneg6_reg),
        .out_valid (dv_unused_valid),
        .quo       (qhi),
        .ovf       (hi_ovf),
        .side_out  (hi_neg_d)
    );

    logic           dv_miss;
    logic           lo_neg_d;
    logic [6*W-1:0] dv_vec;
    logic           lo_ok;
    logic           hi_ok;

    assign {dv_miss, lo_neg_d, dv_vec} = dv_side;
    assign lo_ok = !lo_neg_d && !lo_ovf && (qlo <= mr_reg);
    assign hi_ok = !hi_neg_d && !hi_ovf && (qhi <= mr_reg);

    // ---------------- stage 7: pick crossing ----------------
    logic                v7_reg;
    logic                hit7_reg;
    logic [QW-1:0]       t7_reg;
    logic [6*W-1:0]      vec7_reg;

    // ---------------- stage 8: t times direction ----------------
    logic                  v8_reg;
    logic                  hit8_reg;
    logic signed [2*W-1:0] prod8_reg [0:2];
    logic signed [W-1:0]   org8_reg  [0:2];

    logic signed [W-1:0] org7_w [0:2];
    logic signed [W-1:0] dir7_w [0:2];
    logic signed [W-1:0] t7_s;

    assign {org7_w[0], org7_w[1], org7_w[2], dir7_w[0], dir7_w[1], dir7_w[2]} = vec7_reg;
    assign t7_s = $signed({1'b0, t7_reg});

    // ---------------- stage 9: add origin and saturate ----------------
    logic                  hit_reg;
    logic signed [W-1:0]   pt_reg [0:2];
    logic signed [W-1:0]   pt_w   [0:2];

    for (genvar i = 0; i < 3; i++) begin : g_point
        logic signed [2*W-1:0] sh;
        logic signed [SUMW-1:0] sum;
        logic                   sat_hi;
        logic                   sat_lo;

        assign sh     = prod8_reg[i] >>> FRAC_BITS;
        assign sum    = SUMW'(sh) + SUMW'(org8_reg[i]);
        assign sat_hi = !sum[SUMW-1] && (|sum[SUMW-2:W-1]);
        assign sat_lo = sum[SUMW-1] && !(&sum[SUMW-2:W-1]);
        assign pt_w[i] = !hit8_reg ? '0
                       : sat_hi ? {1'b0, {(W-1){1'b1}}}
                       : sat_lo ? {1'b1, {(W-1){1'b0}}}
                       : sum[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v7_reg        <= dv_valid;
            v8_reg        <= v7_reg;
            out_valid_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit7_reg <= !dv_miss && (lo_ok || hi_ok);
            t7_reg   <= lo_ok ? qlo : qhi;
            vec7_reg <= dv_vec;

            hit8_reg <= hit7_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod8_reg[i] <= (2*W)'(t7_s) * (2*W)'(dir7_w[i]);
                org8_reg[i]  <= org7_w[i];
                pt_reg[i]    <= pt_w[i];
            end
            hit_reg <= hit8_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign point_x   = pt_reg[0];
    assign point_y   = pt_reg[1];
    assign point_z   = pt_reg[2];

endmodule

`default_nettype wire

// ===== tb/sv/tb_ray_sphere_intersection_core.sv =====
// Self-checking testbench for ray_sphere_intersection_core: random and directed rays
// against an exact wide-integer intersection predictor. Depends on rsi_pkg and the core.
`default_nettype none

module tb_ray_sphere_intersection_core;

    localparam int LIMIT = 400000;
    localparam int DRAIN = 130;

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
    } ray_t;

    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] p;
    } crossing_t;

    class hit_scoreboard;
        crossing_t pending[$];
        int        errors  = 0;
        int        checked = 0;

        function void note(crossing_t e);
            pending.push_back(e);
        endfunction

        function void check(crossing_t a);
            crossing_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0d", $realtime, a.hit);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.hit !== a.hit)
            begin
                $display("%0t: hit expected %0d actual %0d", $realtime, e.hit, a.hit);
                errors++;
            end
            for (int i = 0; i < 3; i++)
                if (e.p[i] !== a.p[i])
                begin
                    $display("%0t: point[%0d] expected %h actual %h", $realtime, i, e.p[i],
                             a.p[i]);
                    errors++;
                end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wen = 0;
    logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
    logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        hit;
    logic signed [31:0] point_x, point_y, point_z;

    logic [2:0][31:0] centre;
    logic [30:0]      radius;
    logic [30:0]      range_max;
    bit               quiet = 0;
    int               cycles = 0;
    int               rays_sent = 0;
    int               hits_seen = 0;
    hit_scoreboard    sb;

    ray_sphere_intersection_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .origin_z  (origin_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic wide_t sx(logic [31:0] x);
        sx = {{160{x[31]}}, x};
    endfunction

    function automatic crossing_t trace_ray(ray_t r);
        wide_t     dd, od, oo, v, dw, rr, delta, root, cand, negod, num, n, lim, t, p, lo, hi;
        wide_t     one;
        crossing_t res;
        bit        ok;
        res = '0;
        one = 1;
        dd = 0;
        od = 0;
        oo = 0;
        for (int i = 0; i < 3; i++)
        begin
            v  = sx(r.o[i]) - sx(centre[i]);
            dw = sx(r.d[i]);
            dd = dd + dw * dw;
            od = od + v * dw;
            oo = oo + v * v;
        end
        if (dd == 0)
            return res;
        rr = 0;
        rr[30:0] = radius;
        oo = oo - rr * rr;
        delta = od * od - dd * oo;
        if (delta < 0)
            return res;
        root = 0;
        for (int b = 69; b >= 0; b--)
        begin
            cand = root | (one << b);
            if (cand * cand <= delta)
                root = cand;
        end
        negod = -od;
        ok = 0;
        lim = 0;
        lim[31:0] = {1'b0, range_max};
        lim = dd * (lim + 1);
        t = 0;
        // nearer crossing first, then the farther one
        for (int k = 0; k < 2; k++)
        begin
            num = (k == 0) ? negod - root : negod + root;
            if (!ok && num >= 0)
            begin
                n = num <<< rsi_pkg::FRAC_BITS;
                if (n < lim)
                begin
                    t = n / dd;
                    ok = 1;
                end
            end
        end
        if (!ok)
            return res;
        res.hit = 1;
        lo = -(one <<< 31);
        hi = (one <<< 31) - 1;
        for (int i = 0; i < 3; i++)
        begin
            p = sx(r.o[i]) + ((t * sx(r.d[i])) >>> rsi_pkg::FRAC_BITS);
            if (p < lo)
                p = lo;
            if (p > hi)
                p = hi;
            res.p[i] = p[31:0];
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("ray_sphere_intersection_core test failed");
            $finish;
        end
    end

    // note each ray transfer, check each result transfer
    always @(posedge clk)
    begin
        ray_t      r;
        crossing_t a;
        if (rst_n && in_valid && !in_stall)
        begin
            r.o = {origin_z, origin_y, origin_x};
            r.d = {dir_z, dir_y, dir_x};
            sb.note(trace_ray(r));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            a.hit = hit;
            a.p = {point_z, point_y, point_x};
            if (hit)
                hits_seen <= hits_seen + 1;
            sb.check(a);
        end
    end

    always @(posedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 13);

    task automatic cfg_write(logic [rsi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            rsi_pkg::CFG_CENTER_X:  centre[0] = data;
            rsi_pkg::CFG_CENTER_Y:  centre[1] = data;
            rsi_pkg::CFG_CENTER_Z:  centre[2] = data;
            rsi_pkg::CFG_RADIUS:    radius = data[30:0];
            rsi_pkg::CFG_MAX_RANGE: range_max = data[30:0];
            default: ;
        endcase
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_ray(ray_t r);
        while (!quiet && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        origin_x <= r.o[0];
        origin_y <= r.o[1];
        origin_z <= r.o[2];
        dir_x    <= r.d[0];
        dir_y    <= r.d[1];
        dir_z    <= r.d[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rays_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_t r;
        r.o = {oz, oy, ox};
        r.d = {dz, dy, dx};
        return r;
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        int   kind;
        int   sh;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.o[i] = $urandom;
                r.d[i] = $urandom;
            end
        end
        else if (kind < 30)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.o[i] = $urandom_range(2 ** 22) - 2 ** 21;
                r.d[i] = $urandom_range(2 ** 18) - 2 ** 17;
            end
        end
        else
        begin
            // aim roughly at the sphere from a random offset
            sh = $urandom_range(0, 6);
            for (int i = 0; i < 3; i++)
            begin
                r.o[i] = centre[i] + ($urandom_range(2 ** 21) - 2 ** 20);
                r.d[i] = ((centre[i] - r.o[i]) >>> sh) + ($urandom_range(2 ** 14) - 2 ** 13);
            end
            if ($urandom_range(9) == 0)
                r.d = '0;
        end
        return r;
    endfunction

    localparam int ONE = 65536;

    initial
    begin
        logic [31:0] rnd_c;
        sb = new();
        centre = '0;
        radius = 31'(ONE);
        range_max = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unit sphere at the origin, default range
        send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0));
        send_ray(mk_ray(-5 * ONE, 3 * ONE, 0, ONE, 0, 0));
        send_ray(mk_ray(-5 * ONE, 0, 0, 0, 0, 0));
        send_ray(mk_ray(-5 * ONE, ONE, 0, ONE, 0, 0));
        send_ray(mk_ray(0, 0, 0, 0, ONE, 0));
        send_ray(mk_ray(5 * ONE, 0, 0, ONE, 0, 0));
        send_ray(mk_ray(-5 * ONE, 0, 0, -ONE, 0, 0));
        send_ray(mk_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        send_ray(mk_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_ray(mk_ray(0, 0, ONE / 2, 32'sh7fffffff, 0, 0));
        send_ray(mk_ray(-5 * ONE, 0, 0, 1, 0, 0));
        send_ray(mk_ray(0, 0, -7 * ONE, 0, 0, ONE));
        drain();

        // directed: short range, stray index writes, degenerate and huge radius
        cfg_write(rsi_pkg::CFG_MAX_RANGE, 32'd4 * ONE);
        cfg_write(3'd5, $urandom);
        cfg_write(3'd7, $urandom);
        send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0));
        send_ray(mk_ray(-3 * ONE, 0, 0, ONE, 0, 0));
        drain();
        cfg_write(rsi_pkg::CFG_MAX_RANGE, 32'd0);
        send_ray(mk_ray(-ONE, 0, 0, ONE, 0, 0));
        send_ray(mk_ray(0, 0, 0, ONE, 0, 0));
        drain();
        cfg_write(rsi_pkg::CFG_RADIUS, 32'hffffffff);
        cfg_write(rsi_pkg::CFG_MAX_RANGE, 32'h7fffffff);
        cfg_write(rsi_pkg::CFG_CENTER_X, 32'h80000000);
        cfg_write(rsi_pkg::CFG_CENTER_Y, 32'h7fffffff);
        cfg_write(rsi_pkg::CFG_CENTER_Z, 32'h80000000);
        send_ray(mk_ray(0, 0, 0, ONE, 0, 0));
        send_ray(mk_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -ONE, ONE, -ONE));
        drain();
        cfg_write(rsi_pkg::CFG_RADIUS, 32'd0);
        cfg_write(rsi_pkg::CFG_CENTER_X, 32'd0);
        cfg_write(rsi_pkg::CFG_CENTER_Y, 32'd0);
        cfg_write(rsi_pkg::CFG_CENTER_Z, 32'd0);
        send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0));
        send_ray(mk_ray(-5 * ONE, 1, 0, ONE, 0, 0));
        drain();

        // random phases, each with a fresh sphere
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rnd_c = (ph == 5) ? $urandom : $urandom_range(2 ** 24) - 2 ** 23;
                cfg_write(rsi_pkg::cfg_idx_t'(i), rnd_c);
            end
            case (ph)
                0:       cfg_write(rsi_pkg::CFG_RADIUS, $urandom_range(4 * ONE, ONE / 4));
                1:       cfg_write(rsi_pkg::CFG_RADIUS, 32'h7fffffff);
                2:       cfg_write(rsi_pkg::CFG_RADIUS, 32'd0);
                default: cfg_write(rsi_pkg::CFG_RADIUS,
                                   $urandom_range(2 ** 20, 1) | ($urandom & 32'h80000000));
            endcase
            case (ph)
                1:       cfg_write(rsi_pkg::CFG_MAX_RANGE, 32'd0);
                3:       cfg_write(rsi_pkg::CFG_MAX_RANGE, 32'hffffffff);
                default: cfg_write(rsi_pkg::CFG_MAX_RANGE, $urandom_range(8 * ONE, ONE / 8));
            endcase
            cfg_write(rsi_pkg::cfg_idx_t'($urandom_range(7, 5)), $urandom);
            for (int k = 0; k < 225; k++)
            begin
                quiet = (ph == 2) && (k >= 40) && (k < 160);
                send_ray(random_ray());
            end
            quiet = 0;
            drain();
        end

        $display("sent %0d rays over several sphere settings, %0d results checked, %0d hits",
                 rays_sent, sb.checked, hits_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ray_sphere_intersection_core test passed");
        else
            $display("ray_sphere_intersection_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
